// ----- design/eiec_pkg.sv -----
package eiec_pkg;

  localparam int unsigned LINE_COUNT = 16;
  localparam int unsigned PORT_COUNT = 5;

  localparam int unsigned LINE_W     = 16;
  localparam int unsigned PORT_SEL_W = 3;
  localparam int unsigned PSEL_W     = LINE_W * PORT_SEL_W;
  localparam int unsigned IRQ_W      = 7;

  // lines 0-4 have an irq each, 5-9 and 10-15 share one
  localparam int unsigned SINGLE_IRQS = 5;
  localparam int unsigned GRP1_LO     = 5;
  localparam int unsigned GRP1_HI     = 9;
  localparam int unsigned GRP2_LO     = 10;
  localparam int unsigned GRP2_HI     = 15;
  localparam int unsigned GRP1_IRQ    = 5;
  localparam int unsigned GRP2_IRQ    = 6;

  localparam logic [LINE_W-1:0] LIVE_MASK =
    LINE_W'((33'h1 << LINE_COUNT) - 33'h1);

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_TRIGGER = 2'd2
  } opcode_e;

  typedef logic [PORT_SEL_W-1:0] port_sel_t;
  localparam port_sel_t PORT_A = 3'd0;
  localparam port_sel_t PORT_B = 3'd1;
  localparam port_sel_t PORT_C = 3'd2;
  localparam port_sel_t PORT_D = 3'd3;
  localparam port_sel_t PORT_E = 3'd4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = PSEL_W;
  localparam logic [CFG_IDX_W-1:0] CFG_RISING     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLING    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IRQ_MASK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EVENT_MASK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_SEL   = 3'd4;

  typedef struct packed {
    logic [LINE_W-1:0] rising;
    logic [LINE_W-1:0] falling;
    logic [LINE_W-1:0] irq_mask;
    logic [LINE_W-1:0] event_mask;
  } cfg_t;

  typedef struct packed {
    logic [LINE_W-1:0] pending;
    logic [IRQ_W-1:0]  irq;
    logic [LINE_W-1:0] events;
  } result_t;

endpackage

// ----- design/eiec_in_if.sv -----
interface eiec_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] port_a_pins;
  logic [15:0] port_b_pins;
  logic [15:0] port_c_pins;
  logic [15:0] port_d_pins;
  logic [15:0] port_e_pins;
  logic [15:0] write_data;

  modport source (
    output valid, opcode, port_a_pins, port_b_pins, port_c_pins, port_d_pins,
           port_e_pins, write_data,
    input  ready
  );

  modport sink (
    input  valid, opcode, port_a_pins, port_b_pins, port_c_pins, port_d_pins,
           port_e_pins, write_data,
    output ready
  );
endinterface

// ----- design/eiec_out_if.sv -----
interface eiec_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pending_bits;
  logic [6:0]  irq_lines;
  logic [15:0] event_pulses;

  modport source (
    output valid, pending_bits, irq_lines, event_pulses,
    input  ready
  );

  modport sink (
    input  valid, pending_bits, irq_lines, event_pulses,
    output ready
  );
endinterface

// ----- design/eiec_line_mux.sv -----
module eiec_line_mux (
  input  logic [eiec_pkg::LINE_W-1:0] port_a_i,
  input  logic [eiec_pkg::LINE_W-1:0] port_b_i,
  input  logic [eiec_pkg::LINE_W-1:0] port_c_i,
  input  logic [eiec_pkg::LINE_W-1:0] port_d_i,
  input  logic [eiec_pkg::LINE_W-1:0] port_e_i,
  input  logic [eiec_pkg::PSEL_W-1:0] port_select_i,
  output logic [eiec_pkg::LINE_W-1:0] levels_o
);

  for (genvar l = 0; l < eiec_pkg::LINE_W; l++) begin : g_line
    eiec_pkg::port_sel_t sel;
    eiec_pkg::port_sel_t sel_ok;
    logic                lvl;

    assign sel = port_select_i[l*eiec_pkg::PORT_SEL_W +: eiec_pkg::PORT_SEL_W];
    // a select past the last port falls back to port a
    assign sel_ok = (32'(sel) < eiec_pkg::PORT_COUNT) ? sel : eiec_pkg::PORT_A;

    always_comb begin
      unique case (sel_ok)
        eiec_pkg::PORT_A: lvl = port_a_i[l];
        eiec_pkg::PORT_B: lvl = port_b_i[l];
        eiec_pkg::PORT_C: lvl = port_c_i[l];
        eiec_pkg::PORT_D: lvl = port_d_i[l];
        eiec_pkg::PORT_E: lvl = port_e_i[l];
        default:          lvl = port_a_i[l];
      endcase
    end

    assign levels_o[l] = lvl;
  end

endmodule

// ----- design/eiec_edge_logic.sv -----
module eiec_edge_logic (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        advance_i,
  input  logic [1:0]                  opcode_i,
  input  logic [eiec_pkg::LINE_W-1:0] levels_i,
  input  logic [eiec_pkg::LINE_W-1:0] data_i,
  input  eiec_pkg::cfg_t              cfg_i,
  output eiec_pkg::result_t           res_o
);

  logic [eiec_pkg::LINE_W-1:0] prev_q, prev_d;
  logic [eiec_pkg::LINE_W-1:0] pend_q, pend_d;
  logic [eiec_pkg::LINE_W-1:0] data, rise, fall, edges, events, active;

  always_comb begin
    data   = data_i & eiec_pkg::LIVE_MASK;
    rise   = levels_i & ~prev_q & cfg_i.rising;
    fall   = ~levels_i & prev_q & cfg_i.falling;
    edges  = (rise | fall) & eiec_pkg::LIVE_MASK;
    prev_d = prev_q;
    pend_d = pend_q;
    events = '0;
    unique case (eiec_pkg::opcode_e'(opcode_i))
      eiec_pkg::OP_SAMPLE: begin
        pend_d = pend_q | edges;
        events = edges & cfg_i.event_mask;
        prev_d = levels_i;
      end
      eiec_pkg::OP_CLEAR:   pend_d = pend_q & ~data;
      eiec_pkg::OP_TRIGGER: pend_d = pend_q | data;
      default: ;
    endcase
    active = pend_d & cfg_i.irq_mask;
  end

  assign res_o.pending = pend_d;
  assign res_o.events  = events;
  assign res_o.irq[eiec_pkg::SINGLE_IRQS-1:0] = active[eiec_pkg::SINGLE_IRQS-1:0];
  assign res_o.irq[eiec_pkg::GRP1_IRQ] = |active[eiec_pkg::GRP1_HI:eiec_pkg::GRP1_LO];
  assign res_o.irq[eiec_pkg::GRP2_IRQ] = |active[eiec_pkg::GRP2_HI:eiec_pkg::GRP2_LO];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      pend_q <= '0;
    end else if (advance_i) begin
      prev_q <= prev_d;
      pend_q <= pend_d;
    end
  end

endmodule

// ----- design/external_interrupt_edge_controller_core.sv -----
// path: an accepted transaction waits in the input register and moves to the result register when that is free
// throughput: one transaction per cycle while the result side is ready; with the result stalled
// one more transaction fits in the input register, then the input stalls until the result is taken
// reset: rst_ni is asynchronous, active low; clears all config registers, the previous
// levels, the pending register and both valid flags
module external_interrupt_edge_controller_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [eiec_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [eiec_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  eiec_in_if.sink                          sample_i,
  eiec_out_if.source                       result_o
);

  // config registers
  eiec_pkg::cfg_t              cfg_q;
  logic [eiec_pkg::PSEL_W-1:0] psel_q;

  // input register stage
  logic                        s1_valid_q;
  logic [1:0]                  s1_op_q;
  logic [eiec_pkg::LINE_W-1:0] s1_pa_q, s1_pb_q, s1_pc_q, s1_pd_q, s1_pe_q;
  logic [eiec_pkg::LINE_W-1:0] s1_data_q;

  // result register stage
  logic                        out_valid_q;
  eiec_pkg::result_t           out_q;

  logic                        out_free, s1_adv, accept;
  logic [eiec_pkg::LINE_W-1:0] levels;
  eiec_pkg::result_t           res;

  // result register can take a new value when empty or being drained
  assign out_free = !out_valid_q || result_o.ready;
  assign s1_adv   = s1_valid_q && out_free;
  assign sample_i.ready = !s1_valid_q || out_free;
  assign accept   = sample_i.valid && sample_i.ready;

  // config write port, writes past the last register are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= '0;
      psel_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        eiec_pkg::CFG_RISING:     cfg_q.rising     <= cfg_wdata_i[eiec_pkg::LINE_W-1:0];
        eiec_pkg::CFG_FALLING:    cfg_q.falling    <= cfg_wdata_i[eiec_pkg::LINE_W-1:0];
        eiec_pkg::CFG_IRQ_MASK:   cfg_q.irq_mask   <= cfg_wdata_i[eiec_pkg::LINE_W-1:0];
        eiec_pkg::CFG_EVENT_MASK: cfg_q.event_mask <= cfg_wdata_i[eiec_pkg::LINE_W-1:0];
        eiec_pkg::CFG_PORT_SEL:   psel_q           <= cfg_wdata_i[eiec_pkg::PSEL_W-1:0];
        default: ;
      endcase
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q   <= sample_i.opcode;
      s1_pa_q   <= sample_i.port_a_pins;
      s1_pb_q   <= sample_i.port_b_pins;
      s1_pc_q   <= sample_i.port_c_pins;
      s1_pd_q   <= sample_i.port_d_pins;
      s1_pe_q   <= sample_i.port_e_pins;
      s1_data_q <= sample_i.write_data;
    end
    if (s1_adv) begin
      out_q <= res;
    end
  end

  // per-line port selection
  eiec_line_mux u_line_mux (
    .port_a_i      (s1_pa_q),
    .port_b_i      (s1_pb_q),
    .port_c_i      (s1_pc_q),
    .port_d_i      (s1_pd_q),
    .port_e_i      (s1_pe_q),
    .port_select_i (psel_q),
    .levels_o      (levels)
  );

  // edge detect, pending update and irq grouping; state moves on s1_adv
  eiec_edge_logic u_edge_logic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (s1_adv),
    .opcode_i  (s1_op_q),
    .levels_i  (levels),
    .data_i    (s1_data_q),
    .cfg_i     (cfg_q),
    .res_o     (res)
  );

  assign result_o.valid        = out_valid_q;
  assign result_o.pending_bits = out_q.pending;
  assign result_o.irq_lines    = out_q.irq;
  assign result_o.event_pulses = out_q.events;

  // both stages full and result stalled: no new transaction may enter
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !result_o.ready |-> !sample_i.ready)
    else $error("input accepted while both stages are blocked");

  // every event pulse must also be pending in the same result
  a_event_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.events & ~out_q.pending) == '0))
    else $error("event pulse without pending bit");

  // a clear transaction leaves none of its lines pending
  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && (s1_op_q == eiec_pkg::OP_CLEAR)
    |=> ((out_q.pending & $past(s1_data_q & eiec_pkg::LIVE_MASK)) == '0))
    else $error("cleared line still pending");

endmodule

// ----- verif/eiec_checker.sv -----
module eiec_checker
  import eiec_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  eiec_in_if                    sample_i,
  eiec_out_if                   result_i,
  output int unsigned           mismatch_count_o,
  output int unsigned           outstanding_o
);

  cfg_t              settings;
  logic [PSEL_W-1:0] line_port_sel;
  logic [LINE_W-1:0] last_levels;
  logic [LINE_W-1:0] pending_model;
  result_t           expected_q[$];
  int unsigned       fault_count;

  function automatic logic [LINE_W-1:0] selected_levels(input logic [PSEL_W-1:0] psel);
    logic [LINE_W-1:0] levels;
    port_sel_t         sel;
    levels = '0;
    for (int ln = 0; ln < LINE_W; ln++) begin
      sel = psel[ln*PORT_SEL_W +: PORT_SEL_W];
      case (sel)
        PORT_B:  levels[ln] = sample_i.port_b_pins[ln];
        PORT_C:  levels[ln] = sample_i.port_c_pins[ln];
        PORT_D:  levels[ln] = sample_i.port_d_pins[ln];
        PORT_E:  levels[ln] = sample_i.port_e_pins[ln];
        // port A, and any select past the last port
        default: levels[ln] = sample_i.port_a_pins[ln];
      endcase
    end
    return levels;
  endfunction

  function automatic logic [IRQ_W-1:0] group_irq(input logic [LINE_W-1:0] active);
    logic [IRQ_W-1:0] irq;
    irq                    = '0;
    irq[SINGLE_IRQS-1:0]   = active[SINGLE_IRQS-1:0];
    irq[GRP1_IRQ]          = |active[GRP1_HI:GRP1_LO];
    irq[GRP2_IRQ]          = |active[GRP2_HI:GRP2_LO];
    return irq;
  endfunction

  // advances the model state by one accepted transaction
  function automatic result_t predict_item();
    logic [LINE_W-1:0] levels;
    logic [LINE_W-1:0] edges;
    logic [LINE_W-1:0] data;
    result_t           res;
    data       = sample_i.write_data & LIVE_MASK;
    res.events = '0;
    case (sample_i.opcode)
      OP_SAMPLE: begin
        levels        = selected_levels(line_port_sel);
        edges         = ((levels & ~last_levels & settings.rising) |
                         (~levels & last_levels & settings.falling)) & LIVE_MASK;
        pending_model = pending_model | edges;
        res.events    = edges & settings.event_mask;
        last_levels   = levels;
      end
      OP_CLEAR:   pending_model = pending_model & ~data;
      OP_TRIGGER: pending_model = pending_model | data;
      default: ;
    endcase
    res.pending = pending_model;
    res.irq     = group_irq(pending_model & settings.irq_mask);
    return res;
  endfunction

  function automatic bit field_differs(input string name, input logic [LINE_W-1:0] want,
                                       input logic [LINE_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    bit      bad;
    if (!rst_ni) begin
      settings      = '0;
      line_port_sel = '0;
      last_levels   = '0;
      pending_model = '0;
      fault_count   = 0;
      expected_q.delete();
      mismatch_count_o <= 0;
      outstanding_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RISING:     settings.rising     = cfg_wdata_i[LINE_W-1:0];
          CFG_FALLING:    settings.falling    = cfg_wdata_i[LINE_W-1:0];
          CFG_IRQ_MASK:   settings.irq_mask   = cfg_wdata_i[LINE_W-1:0];
          CFG_EVENT_MASK: settings.event_mask = cfg_wdata_i[LINE_W-1:0];
          CFG_PORT_SEL:   line_port_sel       = cfg_wdata_i[PSEL_W-1:0];
          default: ;
        endcase
      end
      if (sample_i.valid && sample_i.ready) begin
        expected_q.push_back(predict_item());
      end
      if (result_i.valid && result_i.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual pending %h irq %h events %h",
                   $time, result_i.pending_bits, result_i.irq_lines, result_i.event_pulses);
          fault_count++;
        end else begin
          want = expected_q.pop_front();
          bad  = field_differs("pending_bits", want.pending, result_i.pending_bits);
          bad |= field_differs("irq_lines", LINE_W'(want.irq), LINE_W'(result_i.irq_lines));
          bad |= field_differs("event_pulses", want.events, result_i.event_pulses);
          if (bad) begin
            fault_count++;
          end
        end
      end
      mismatch_count_o <= fault_count;
      outstanding_o    <= expected_q.size();
    end
  end

endmodule

// ----- verif/external_interrupt_edge_controller_core_tb.sv -----
module external_interrupt_edge_controller_core_tb;
  import eiec_pkg::*;

  // opcode 3 has no meaning in the block, it must leave everything alone
  localparam logic [1:0]           OP_UNUSED     = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX   = {CFG_IDX_W{1'b1}};

  localparam int unsigned IDLE_PERCENT    = 29;
  localparam int unsigned HOLD_OFF_CYCLES = 60;
  localparam int unsigned SETTLE_CYCLES   = 4;
  localparam int unsigned RANDOM_PHASES   = 11;
  localparam int unsigned PHASE_ITEMS     = 100;
  localparam int unsigned SQUEEZE_PHASE   = 3;
  localparam int unsigned STEADY_PHASE    = 6;
  localparam int unsigned CYCLE_LIMIT     = 200000;

  typedef struct packed {
    logic [1:0]                        opcode;
    logic [PORT_COUNT-1:0][LINE_W-1:0] pins;
    logic [LINE_W-1:0]                 write_data;
  } sample_item_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  eiec_in_if  sample_bus ();
  eiec_out_if result_bus ();

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned cycle_count = 0;

  // the result side looks at both, the input side at steady_flow; only the main stimulus process writes them
  bit steady_flow    = 1'b0;
  bit squeeze_output = 1'b0;

  logic [PORT_COUNT-1:0][LINE_W-1:0] last_pins = '0;

  always #2 clk_i = ~clk_i;

  external_interrupt_edge_controller_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (sample_bus),
    .result_o    (result_bus)
  );

  // watches both channels and the register port, predicts and compares
  eiec_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .sample_i         (sample_bus),
    .result_i         (result_bus),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  // watchdog: a hung handshake or a lost result ends here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random back-pressure, one long hold-off while the input keeps coming
  initial begin
    bit squeeze_done;
    squeeze_done = 1'b0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (squeeze_output && !squeeze_done) begin
        squeeze_done = 1'b1;
        result_bus.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      result_bus.ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  function automatic sample_item_t make_item(input logic [1:0] op,
                                             input logic [LINE_W-1:0] a, b, c, d, e,
                                             input logic [LINE_W-1:0] data);
    sample_item_t it;
    it.opcode       = op;
    it.pins[PORT_A] = a;
    it.pins[PORT_B] = b;
    it.pins[PORT_C] = c;
    it.pins[PORT_D] = d;
    it.pins[PORT_E] = e;
    it.write_data   = data;
    return it;
  endfunction

  // mostly samples; pins either hold, flip one line, or jump anywhere
  function automatic sample_item_t random_item();
    sample_item_t it;
    int unsigned  pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      it.opcode = OP_SAMPLE;
    end else if (pick < 75) begin
      it.opcode = OP_CLEAR;
    end else if (pick < 90) begin
      it.opcode = OP_TRIGGER;
    end else begin
      it.opcode = OP_UNUSED;
    end
    for (int p = 0; p < PORT_COUNT; p++) begin
      case ($urandom_range(3))
        0:       it.pins[p] = last_pins[p];
        1:       it.pins[p] = last_pins[p] ^ (LINE_W'(1) << $urandom_range(LINE_W - 1));
        default: it.pins[p] = LINE_W'($urandom);
      endcase
    end
    last_pins     = it.pins;
    it.write_data = ($urandom_range(3) == 0) ? '1 : LINE_W'($urandom);
    return it;
  endfunction

  function automatic logic [LINE_W-1:0] random_mask();
    case ($urandom_range(4))
      0:       return '0;
      1:       return '1;
      default: return LINE_W'($urandom);
    endcase
  endfunction

  function automatic logic [PSEL_W-1:0] random_port_sel();
    logic [PSEL_W-1:0] psel;
    for (int ln = 0; ln < LINE_W; ln++) begin
      psel[ln*PORT_SEL_W +: PORT_SEL_W] = PORT_SEL_W'($urandom_range(7));
    end
    return psel;
  endfunction

  // one register write per edge; write enable stays high across a burst
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  // upper bits of the 16-bit registers carry junk the block must drop
  task automatic load_settings(input logic [LINE_W-1:0] rise, fall, irq_mask, ev_mask,
                               input logic [PSEL_W-1:0] psel);
    write_reg(CFG_RISING,     {$urandom, rise});
    write_reg(CFG_FALLING,    {$urandom, fall});
    write_reg(CFG_IRQ_MASK,   {$urandom, irq_mask});
    write_reg(CFG_EVENT_MASK, {$urandom, ev_mask});
    write_reg(CFG_PORT_SEL,   psel);
    // index past the register list, must be ignored
    write_reg(CFG_IDX_W'($urandom_range(CFG_PORT_SEL + 1, CFG_IDX_MAX)),
              CFG_DATA_W'({$urandom, $urandom}));
    cfg_we_i <= 1'b0;
  endtask

  // called at a rising edge; returns at the edge where the transaction was taken
  task automatic send_item(input sample_item_t it);
    while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
      sample_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_bus.valid       <= 1'b1;
    sample_bus.opcode      <= it.opcode;
    sample_bus.port_a_pins <= it.pins[PORT_A];
    sample_bus.port_b_pins <= it.pins[PORT_B];
    sample_bus.port_c_pins <= it.pins[PORT_C];
    sample_bus.port_d_pins <= it.pins[PORT_D];
    sample_bus.port_e_pins <= it.pins[PORT_E];
    sample_bus.write_data  <= it.write_data;
    @(posedge clk_i);
    while (sample_bus.ready !== 1'b1) @(posedge clk_i);
  endtask

  // stop offering and wait until every result is back and the pipe is empty
  task automatic drain();
    sample_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    rst_ni                 <= 1'b0;
    cfg_we_i               <= 1'b0;
    cfg_idx_i              <= '0;
    cfg_wdata_i            <= '0;
    sample_bus.valid       <= 1'b0;
    sample_bus.opcode      <= OP_SAMPLE;
    sample_bus.port_a_pins <= '0;
    sample_bus.port_b_pins <= '0;
    sample_bus.port_c_pins <= '0;
    sample_bus.port_d_pins <= '0;
    sample_bus.port_e_pins <= '0;
    sample_bus.write_data  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: no edge enabled, all masks closed, every line on port A
    send_item(make_item(OP_SAMPLE, '1, '0, '0, '0, '0, '0));
    send_item(make_item(OP_TRIGGER, '0, '0, '0, '0, '0, 16'h8001));
    send_item(make_item(OP_SAMPLE, '0, '1, '1, '1, '1, '0));
    send_item(make_item(OP_CLEAR, '0, '0, '0, '0, '0, 16'h0001));
    send_item(make_item(OP_UNUSED, '0, '0, '0, '0, '0, '1));
    drain();

    // everything open, port A: full rise and fall, clears per irq group
    load_settings('1, '1, '1, '1, '0);
    send_item(make_item(OP_SAMPLE, '0, '0, '0, '0, '0, '0));
    send_item(make_item(OP_SAMPLE, '1, '0, '0, '0, '0, '0));
    send_item(make_item(OP_UNUSED, '1, '0, '0, '0, '0, '1));
    send_item(make_item(OP_CLEAR, '1, '0, '0, '0, '0, 16'h03E0));
    send_item(make_item(OP_CLEAR, '1, '0, '0, '0, '0, 16'hFC00));
    send_item(make_item(OP_CLEAR, '1, '0, '0, '0, '0, '1));
    send_item(make_item(OP_SAMPLE, '0, '1, '1, '1, '1, '0));
    send_item(make_item(OP_TRIGGER, '0, '1, '1, '1, '1, 16'h0010));
    send_item(make_item(OP_TRIGGER, '0, '1, '1, '1, '1, '1));
    send_item(make_item(OP_CLEAR, '0, '1, '1, '1, '1, '1));
    drain();

    // every line from port E, other ports toggle against it
    load_settings('1, '1, '1, '1, {LINE_W{PORT_E}});
    send_item(make_item(OP_SAMPLE, '0, '0, '0, '0, '1, '0));
    send_item(make_item(OP_SAMPLE, '1, '1, '1, '1, '0, '0));
    send_item(make_item(OP_CLEAR, '1, '1, '1, '1, '0, '1));
    drain();

    // select past the last port falls back to port A
    load_settings('1, '1, '1, '1, '1);
    send_item(make_item(OP_SAMPLE, '1, '0, '0, '0, '0, '0));
    send_item(make_item(OP_SAMPLE, '0, '1, '1, '1, '1, '0));
    drain();

    // random phases: first fully open, second fully closed, then mixed settings
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        load_settings('1, '1, '1, '1, random_port_sel());
      end else if (phase == 1) begin
        load_settings('0, '0, '0, '0, random_port_sel());
      end else begin
        load_settings(random_mask(), random_mask(), random_mask(), random_mask(),
                      random_port_sel());
      end
      steady_flow = (phase == STEADY_PHASE);
      if (phase == SQUEEZE_PHASE) begin
        squeeze_output = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_item(random_item());
      end
      drain();
      steady_flow = 1'b0;
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
